// File: sv/bcd_pkg.sv
// Shared types and constants for the block cache directory.
// Holds the controller/datapath command and status structs and the status codes.
// No dependencies.
package bcd_pkg;

   localparam int KEY_W   = 48;
   localparam int BLK_W   = 6;
   localparam int AUX_W   = 16;
   localparam int PAIRS_W = 20;
   localparam int DEV_W   = 4;
   localparam int CNT_W   = 32;
   localparam int TALLY_W = 7;
   localparam int IDXO_W  = 6;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_MISMATCH = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;
   localparam logic [1:0] STATUS_NEG_IDX  = 2'd3;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [AUX_W-1:0]   aux_rows;
      logic [PAIRS_W-1:0] pair_count;
      logic [DEV_W-1:0]   device;
   } bcd_record_type;

   typedef struct packed {
      logic [CNT_W-1:0] access;
      logic [CNT_W-1:0] refresh;
   } bcd_counts_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic hit_rd;
      logic hit_wr;
      logic append;
      logic tally_wr;
      logic full_rsp;
   } bcd_cmd_type;

   typedef struct packed {
      logic found;
      logic exhausted;
      logic full;
      logic tally_needed;
   } bcd_status_type;

endpackage

// File: sv/block_cache_directory_unit.sv
// Top level of the block cache directory: controller plus datapath.
// Depends on bcd_pkg, bcd_ctrl and bcd_datapath.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. The key
//   is req_base_address + req_block_number (48-bit wrap). Entries are searched
//   from index 0 upward, one key compare per cycle from a registered memory
//   read, so the search sets the time per request.
//   Exactly one result per request, shown for one cycle with rsp_strobe high.
//   A hit goes on to a count read and a count write after its compare; a miss
//   appends the entry, followed by a tally update when one is needed; a full
//   table gives its result once the search has run through every entry.
//   The next request can be taken in the cycle the result is strobed, so the
//   time per request is set by the search length.
//   The receiver cannot stall: rsp_* must be captured while rsp_strobe is high.
//   csr_refresh_enable is written with csr_valid (csr_ready is always high);
//   write it only while the block is idle.
//   Reset clears the fill level, the refresh enable and the controller; the
//   memories need no clearing pass, only entries below the fill level are used.
module block_cache_directory_unit
   import bcd_pkg::*;
#(
   parameter int ENTRIES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [KEY_W-1:0]    req_base_address,
   input  logic [BLK_W-1:0]    req_block_number,
   input  logic [AUX_W-1:0]    req_aux_rows,
   input  logic [PAIRS_W-1:0]  req_pair_count,
   input  logic [DEV_W-1:0]    req_device_number,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_refresh_enable,
   output logic                rsp_strobe,
   output logic                rsp_hit,
   output logic [IDXO_W-1:0]   rsp_entry_index,
   output logic                rsp_upload,
   output logic [CNT_W-1:0]    rsp_use_count,
   output logic [1:0]          rsp_status
);

   bcd_cmd_type    cmd;
   bcd_status_type stat;

   bcd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   bcd_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_base_address   (req_base_address),
      .req_block_number   (req_block_number),
      .req_aux_rows       (req_aux_rows),
      .req_pair_count     (req_pair_count),
      .req_device_number  (req_device_number),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_refresh_enable (csr_refresh_enable),
      .rsp_strobe         (rsp_strobe),
      .rsp_hit            (rsp_hit),
      .rsp_entry_index    (rsp_entry_index),
      .rsp_upload         (rsp_upload),
      .rsp_use_count      (rsp_use_count),
      .rsp_status         (rsp_status)
   );

endmodule

// File: sv/bcd_ctrl.sv
// Controller state machine of the block cache directory.
// Sequences search, hit update, append and tally update; uses bcd_pkg.
module bcd_ctrl
   import bcd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  bcd_status_type stat,
   output bcd_cmd_type    cmd,
   output logic           busy
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_HIT_RD,
      S_HIT_WR,
      S_MISS,
      S_TALLY
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start && !busy_ff) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            priority if (stat.found) begin
               state_in = S_HIT_RD;
            end else if (stat.exhausted) begin
               state_in = S_MISS;
            end
         end
         S_HIT_RD: begin
            cmd.hit_rd = 1'b1;
            state_in   = S_HIT_WR;
         end
         S_HIT_WR: begin
            cmd.hit_wr = 1'b1;
            state_in   = S_IDLE;
         end
         S_MISS: begin
            if (stat.full) begin
               cmd.full_rsp = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.append = 1'b1;
               state_in   = stat.tally_needed ? S_TALLY : S_IDLE;
            end
         end
         S_TALLY: begin
            cmd.tally_wr = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

// File: sv/bcd_datapath.sv
// Datapath of the block cache directory: entry, count and tally memories,
// the pipelined key compare, counters and the result register; uses bcd_pkg.
module bcd_datapath
   import bcd_pkg::*;
#(
   parameter int ENTRIES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bcd_cmd_type          cmd,
   output bcd_status_type       stat,
   input  logic [KEY_W-1:0]     req_base_address,
   input  logic [BLK_W-1:0]     req_block_number,
   input  logic [AUX_W-1:0]     req_aux_rows,
   input  logic [PAIRS_W-1:0]   req_pair_count,
   input  logic [DEV_W-1:0]     req_device_number,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_refresh_enable,
   output logic                 rsp_strobe,
   output logic                 rsp_hit,
   output logic [IDXO_W-1:0]    rsp_entry_index,
   output logic                 rsp_upload,
   output logic [CNT_W-1:0]     rsp_use_count,
   output logic [1:0]           rsp_status
);

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int FILL_W = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (FILL_W > BLK_W) ? FILL_W : BLK_W;

   bcd_record_type rec_mem   [ENTRIES];
   bcd_counts_type cnt_mem   [ENTRIES];
   logic [TALLY_W-1:0] tally_mem [ENTRIES];

   logic [KEY_W-1:0]   key_ff;
   logic [BLK_W-1:0]   blk_ff;
   logic [AUX_W-1:0]   aux_ff;
   logic [PAIRS_W-1:0] pairs_ff;
   logic [DEV_W-1:0]   dev_ff;

   logic               refresh_enable_ff, refresh_enable_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [FILL_W-1:0]  scan_addr_ff, scan_addr_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]   cmp_idx_ff;
   bcd_record_type     rec_rd_ff;
   logic [IDX_W-1:0]   sel_idx_ff;
   logic               mism_ff;
   bcd_counts_type     cnt_rd_ff;
   logic [IDX_W-1:0]   tally_idx_ff;
   logic [TALLY_W-1:0] tally_rd_ff;

   logic               rsp_strobe_ff, rsp_strobe_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [IDXO_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic               rsp_upload_ff, rsp_upload_in;
   logic [CNT_W-1:0]   rsp_use_ff, rsp_use_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic               issue;
   logic [CMP_W-1:0]   fill_ext, blk_ext, sel_ext, tally_diff, app_ext;
   logic [IDX_W-1:0]   app_idx;
   logic               refresh;
   logic [CNT_W-1:0]   access_new, refresh_new;

   logic               cnt_we;
   logic [IDX_W-1:0]   cnt_waddr;
   bcd_counts_type     cnt_wdata;
   logic               tally_we;
   logic [IDX_W-1:0]   tally_waddr;
   logic [TALLY_W-1:0] tally_wdata;

   always_comb begin
      fill_ext   = CMP_W'(fill_ff);
      blk_ext    = CMP_W'(blk_ff);
      sel_ext    = CMP_W'(sel_idx_ff);
      tally_diff = fill_ext - blk_ext;
      app_idx    = fill_ff[IDX_W-1:0];
      app_ext    = CMP_W'(app_idx);
      issue      = cmd.scan && (scan_addr_ff < fill_ff);

      stat.found        = cmp_valid_ff && (rec_rd_ff.key == key_ff);
      stat.exhausted    = !cmp_valid_ff && !(scan_addr_ff < fill_ff);
      stat.full         = (fill_ff == FILL_W'(ENTRIES));
      stat.tally_needed = (blk_ff != '0) && (fill_ext >= blk_ext);

      refresh     = refresh_enable_ff && (sel_ext != blk_ext);
      access_new  = (cnt_rd_ff.access == '1) ? cnt_rd_ff.access : cnt_rd_ff.access + 1'b1;
      refresh_new = cnt_rd_ff.refresh;
      if (refresh && (cnt_rd_ff.refresh != '1)) begin
         refresh_new = cnt_rd_ff.refresh + 1'b1;
      end
   end

   // Control registers next values
   always_comb begin
      refresh_enable_in = refresh_enable_ff;
      if (csr_valid) begin
         refresh_enable_in = csr_refresh_enable;
      end

      fill_in = fill_ff;
      if (cmd.append) begin
         fill_in = fill_ff + 1'b1;
      end

      scan_addr_in = scan_addr_ff;
      cmp_valid_in = cmp_valid_ff;
      if (cmd.load) begin
         scan_addr_in = '0;
         cmp_valid_in = 1'b0;
      end else if (cmd.scan) begin
         cmp_valid_in = issue;
         if (issue) begin
            scan_addr_in = scan_addr_ff + 1'b1;
         end
      end

      rsp_strobe_in = 1'b0;
      rsp_hit_in    = 1'b0;
      rsp_idx_in    = '0;
      rsp_upload_in = 1'b0;
      rsp_use_in    = '0;
      rsp_status_in = STATUS_OK;
      priority if (cmd.hit_wr) begin
         rsp_strobe_in = 1'b1;
         rsp_hit_in    = 1'b1;
         rsp_idx_in    = sel_ext[IDXO_W-1:0];
         rsp_upload_in = refresh;
         rsp_use_in    = access_new;
         rsp_status_in = mism_ff ? STATUS_MISMATCH : STATUS_OK;
      end else if (cmd.full_rsp) begin
         rsp_strobe_in = 1'b1;
         rsp_status_in = STATUS_FULL;
      end else if (cmd.append && !stat.tally_needed) begin
         rsp_strobe_in = 1'b1;
         rsp_idx_in    = app_ext[IDXO_W-1:0];
         rsp_upload_in = 1'b1;
         rsp_use_in    = CNT_W'(1);
         rsp_status_in = (fill_ext < blk_ext) ? STATUS_NEG_IDX : STATUS_OK;
      end else if (cmd.tally_wr) begin
         rsp_strobe_in = 1'b1;
         rsp_idx_in    = sel_ext[IDXO_W-1:0];
         rsp_upload_in = 1'b1;
         rsp_use_in    = CNT_W'(1);
      end
   end

   // Memory write ports
   always_comb begin
      cnt_we    = cmd.hit_wr || cmd.append;
      cnt_waddr = cmd.append ? app_idx : sel_idx_ff;
      cnt_wdata = cmd.append ? bcd_counts_type'{access: CNT_W'(1), refresh: '0}
                             : bcd_counts_type'{access: access_new, refresh: refresh_new};

      tally_we    = cmd.append || cmd.tally_wr;
      tally_waddr = cmd.append ? app_idx : tally_idx_ff;
      // a block number of zero lands the tally bump on the entry just cleared
      if (cmd.append) begin
         tally_wdata = (blk_ff == '0) ? TALLY_W'(1) : '0;
      end else begin
         tally_wdata = (tally_rd_ff == '1) ? tally_rd_ff : tally_rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         refresh_enable_ff <= 1'b0;
         fill_ff           <= '0;
         scan_addr_ff      <= '0;
         cmp_valid_ff      <= 1'b0;
         rsp_strobe_ff     <= 1'b0;
      end else begin
         refresh_enable_ff <= refresh_enable_in;
         fill_ff           <= fill_in;
         scan_addr_ff      <= scan_addr_in;
         cmp_valid_ff      <= cmp_valid_in;
         rsp_strobe_ff     <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff    <= rsp_hit_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_upload_ff <= rsp_upload_in;
      rsp_use_ff    <= rsp_use_in;
      rsp_status_ff <= rsp_status_in;

      if (cmd.load) begin
         key_ff   <= req_base_address + KEY_W'(req_block_number);
         blk_ff   <= req_block_number;
         aux_ff   <= req_aux_rows;
         pairs_ff <= req_pair_count;
         dev_ff   <= req_device_number;
      end
      if (issue) begin
         cmp_idx_ff <= scan_addr_ff[IDX_W-1:0];
      end
      // hold the first matching entry and its size check
      if (cmd.scan && stat.found) begin
         sel_idx_ff <= cmp_idx_ff;
         mism_ff    <= (rec_rd_ff.aux_rows != aux_ff) || (rec_rd_ff.pair_count != pairs_ff);
      end
      if (cmd.append) begin
         sel_idx_ff   <= app_idx;
         tally_idx_ff <= tally_diff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rec_rd_ff <= rec_mem[scan_addr_ff[IDX_W-1:0]];
      end
      if (cmd.append) begin
         rec_mem[app_idx] <= '{key: key_ff, aux_rows: aux_ff, pair_count: pairs_ff,
                               device: dev_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hit_rd) begin
         cnt_rd_ff <= cnt_mem[sel_idx_ff];
      end
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         tally_rd_ff <= tally_mem[tally_diff[IDX_W-1:0]];
      end
      if (tally_we) begin
         tally_mem[tally_waddr] <= tally_wdata;
      end
   end

   assign csr_ready       = 1'b1;
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_entry_index = rsp_idx_ff;
   assign rsp_upload      = rsp_upload_ff;
   assign rsp_use_count   = rsp_use_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for block_cache_directory_unit: a directed table, then random
// lookups; each result is checked against its table row or an in-bench directory model.
// Depends on bcd_pkg and the block_cache_directory_unit RTL.
module testbench
   import bcd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES = 64;
   localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
   localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

   typedef struct packed {
      logic [KEY_W-1:0]   base;
      logic [BLK_W-1:0]   blk;
      logic [AUX_W-1:0]   aux;
      logic [PAIRS_W-1:0] pairs;
      logic [DEV_W-1:0]   dev;
   } request_type;

   typedef struct packed {
      logic              hit;
      logic [IDXO_W-1:0] idx;
      logic              upload;
      logic [CNT_W-1:0]  uses;
      logic [1:0]        status;
   } lookup_type;

   typedef struct packed {
      logic        refresh;
      request_type req;
      logic        typed;
      lookup_type  want;
   } table_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [KEY_W-1:0]    req_base_address = '0;
   logic [BLK_W-1:0]    req_block_number = '0;
   logic [AUX_W-1:0]    req_aux_rows = '0;
   logic [PAIRS_W-1:0]  req_pair_count = '0;
   logic [DEV_W-1:0]    req_device_number = '0;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_refresh_enable = 1'b0;
   logic                rsp_strobe;
   logic                rsp_hit;
   logic [IDXO_W-1:0]   rsp_entry_index;
   logic                rsp_upload;
   logic [CNT_W-1:0]    rsp_use_count;
   logic [1:0]          rsp_status;

   block_cache_directory_unit #(.ENTRIES(ENTRIES)) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_base_address   (req_base_address),
      .req_block_number   (req_block_number),
      .req_aux_rows       (req_aux_rows),
      .req_pair_count     (req_pair_count),
      .req_device_number  (req_device_number),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_refresh_enable (csr_refresh_enable),
      .rsp_strobe         (rsp_strobe),
      .rsp_hit            (rsp_hit),
      .rsp_entry_index    (rsp_entry_index),
      .rsp_upload         (rsp_upload),
      .rsp_use_count      (rsp_use_count),
      .rsp_status         (rsp_status)
   );

   always #5 clock = ~clock;

   // directory model
   logic [KEY_W-1:0]   mdl_key       [ENTRIES];
   logic [CNT_W-1:0]   mdl_uses      [ENTRIES];
   logic [CNT_W-1:0]   mdl_refreshes [ENTRIES];
   logic [AUX_W-1:0]   mdl_aux       [ENTRIES];
   logic [PAIRS_W-1:0] mdl_pairs     [ENTRIES];
   logic [DEV_W-1:0]   mdl_owner     [ENTRIES];
   logic [TALLY_W-1:0] mdl_tally     [ENTRIES] = '{default: '0};
   int                 mdl_fill = 0;
   logic               mdl_refresh_en = 1'b0;

   lookup_type    pending_lookups [$];
   table_row_type directed_rows [$];
   int            fail_count = 0;
   int            n_hits = 0, n_appends = 0, n_refresh = 0;
   int            n_mismatch = 0, n_full = 0, n_neg = 0;

   function automatic lookup_type directory_lookup(input request_type r);
      lookup_type       o;
      logic [KEY_W-1:0] key;
      int               found;
      int               slot;
      int               tix;
      o = '0;
      key = r.base + KEY_W'(r.blk);
      found = -1;
      for (int i = 0; i < mdl_fill; i++)
         if (found < 0 && mdl_key[i] == key) found = i;
      if (found >= 0) begin
         o.hit = 1'b1;
         o.idx = IDXO_W'(found);
         if (mdl_uses[found] != CNT_MAX) mdl_uses[found] = mdl_uses[found] + 1'b1;
         o.uses = mdl_uses[found];
         if (mdl_refresh_en && found != int'(r.blk)) begin
            if (mdl_refreshes[found] != CNT_MAX)
               mdl_refreshes[found] = mdl_refreshes[found] + 1'b1;
            o.upload = 1'b1;
         end
         // sizes stay as first stored, only flag the difference
         if (r.aux != mdl_aux[found] || r.pairs != mdl_pairs[found])
            o.status = STATUS_MISMATCH;
      end else if (mdl_fill >= ENTRIES) begin
         o.status = STATUS_FULL;
      end else begin
         slot = mdl_fill;
         mdl_key[slot]       = key;
         mdl_uses[slot]      = CNT_W'(1);
         mdl_refreshes[slot] = '0;
         mdl_aux[slot]       = r.aux;
         mdl_pairs[slot]     = r.pairs;
         mdl_owner[slot]     = r.dev;
         mdl_tally[slot]     = '0;
         mdl_fill            = slot + 1;
         o.idx    = IDXO_W'(slot);
         o.uses   = CNT_W'(1);
         o.upload = 1'b1;
         if (slot >= int'(r.blk)) begin
            tix = slot - int'(r.blk);
            if (mdl_tally[tix] != TALLY_MAX) mdl_tally[tix] = mdl_tally[tix] + 1'b1;
         end else begin
            o.status = STATUS_NEG_IDX;
         end
      end
      return o;
   endfunction

   // Lookups of stored keys through a random block number (45% while filling, 80% once full), the rest new keys.
   function automatic request_type random_request();
      request_type r;
      logic [63:0] wide;
      int          e;
      int          hit_pct;
      hit_pct = (mdl_fill < ENTRIES) ? 45 : 80;
      wide = {$urandom(), $urandom()};
      r.base  = wide[KEY_W-1:0];
      r.blk   = BLK_W'($urandom_range(0, 63));
      r.aux   = AUX_W'($urandom());
      r.pairs = PAIRS_W'($urandom());
      r.dev   = DEV_W'($urandom());
      if (mdl_fill > 0 && $urandom_range(1, 100) <= hit_pct) begin
         e = $urandom_range(0, mdl_fill - 1);
         if ($urandom_range(0, 3) == 0) r.blk = BLK_W'(e);
         r.base = mdl_key[e] - KEY_W'(r.blk);
         if ($urandom_range(0, 7) != 0) begin
            r.aux   = mdl_aux[e];
            r.pairs = mdl_pairs[e];
         end
      end else if ($urandom_range(0, 9) == 0) begin
         // push the new key to the edges of the address space
         r.base = ($urandom_range(0, 1) == 1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
      end
      return r;
   endfunction

   function automatic void add_row(input logic rf, input logic [KEY_W-1:0] base,
                                   input logic [BLK_W-1:0] blk, input logic [AUX_W-1:0] aux,
                                   input logic [PAIRS_W-1:0] pairs,
                                   input logic [DEV_W-1:0] dev, input logic typed,
                                   input logic hit, input logic [IDXO_W-1:0] idx,
                                   input logic upload, input logic [CNT_W-1:0] uses,
                                   input logic [1:0] status);
      table_row_type row;
      row.refresh     = rf;
      row.req.base    = base;
      row.req.blk     = blk;
      row.req.aux     = aux;
      row.req.pairs   = pairs;
      row.req.dev     = dev;
      row.typed       = typed;
      row.want.hit    = hit;
      row.want.idx    = idx;
      row.want.upload = upload;
      row.want.uses   = uses;
      row.want.status = status;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   task automatic issue_request(input request_type r, input logic typed,
                                input lookup_type typed_want);
      lookup_type want;
      req_base_address  <= r.base;
      req_block_number  <= r.blk;
      req_aux_rows      <= r.aux;
      req_pair_count    <= r.pairs;
      req_device_number <= r.dev;
      start             <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      want = directory_lookup(r);
      if (typed) want = typed_want;
      pending_lookups.insert(pending_lookups.size(), want);
      if (want.hit) n_hits++;
      if (want.upload && !want.hit) n_appends++;
      if (want.upload && want.hit) n_refresh++;
      if (want.status == STATUS_MISMATCH) n_mismatch++;
      if (want.status == STATUS_FULL) n_full++;
      if (want.status == STATUS_NEG_IDX) n_neg++;
   endtask

   task automatic maybe_idle(input logic allowed);
      if (allowed && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_lookups.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_refresh(input logic value);
      wait_drained();
      csr_refresh_enable <= value;
      csr_valid          <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid      <= 1'b0;
      mdl_refresh_en = value;
   endtask

   task automatic random_phase(input logic rf, input int count, input int calm_tail);
      write_refresh(rf);
      for (int n = 0; n < count; n++) begin
         issue_request(random_request(), 1'b0, '0);
         maybe_idle(n < count - calm_tail);
      end
   endtask

   always @(posedge clock) begin : result_check
      lookup_type seen;
      lookup_type want;
      if (!reset && rsp_strobe) begin
         seen.hit    = rsp_hit;
         seen.idx    = rsp_entry_index;
         seen.upload = rsp_upload;
         seen.uses   = rsp_use_count;
         seen.status = rsp_status;
         if (pending_lookups.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("[%0t] stray result: hit=%0b idx=%0d upload=%0b uses=%0d status=%0d",
                        $time, seen.hit, seen.idx, seen.upload, seen.uses, seen.status);
         end else begin
            want = pending_lookups.pop_front();
            if (seen.hit !== want.hit || seen.idx !== want.idx || seen.upload !== want.upload ||
                seen.uses !== want.uses || seen.status !== want.status) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("[%0t] mismatch: expected hit=%0b idx=%0d upload=%0b uses=%0d %s%0d",
                           $time, want.hit, want.idx, want.upload, want.uses, "status=",
                           want.status);
                  $display("[%0t]           got      hit=%0b idx=%0d upload=%0b uses=%0d %s%0d",
                           $time, seen.hit, seen.idx, seen.upload, seen.uses, "status=",
                           seen.status);
               end
            end
         end
      end
   end

   initial begin
      table_row_type row;
      // key 0 appended, then found again through a wrapped base
      add_row(1'b0, 48'h0, 6'd0, 16'h0, 20'h0, 4'h0,
              1'b1, 1'b0, 6'd0, 1'b1, 32'd1, STATUS_OK);
      add_row(1'b0, 48'h0, 6'd0, 16'h0, 20'h0, 4'h0,
              1'b1, 1'b1, 6'd0, 1'b0, 32'd2, STATUS_OK);
      add_row(1'b0, 48'hFFFF_FFFF_FFFF, 6'd1, 16'h0, 20'h0, 4'h0,
              1'b1, 1'b1, 6'd0, 1'b0, 32'd3, STATUS_OK);
      // block number past the entry index: appended, tally left alone
      add_row(1'b0, 48'hFFFF_FFFF_FFFF, 6'd63, 16'hFFFF, 20'hFFFFF, 4'hF,
              1'b1, 1'b0, 6'd1, 1'b1, 32'd1, STATUS_NEG_IDX);
      add_row(1'b0, 48'h0, 6'd0, 16'h1, 20'h0, 4'h0,
              1'b1, 1'b1, 6'd0, 1'b0, 32'd4, STATUS_MISMATCH);
      add_row(1'b0, 48'h0, 6'd0, 16'h0, 20'h1, 4'h0,
              1'b1, 1'b1, 6'd0, 1'b0, 32'd5, STATUS_MISMATCH);
      add_row(1'b0, 48'd57, 6'd5, 16'hFFFF, 20'hFFFFF, 4'h3,
              1'b1, 1'b1, 6'd1, 1'b0, 32'd2, STATUS_OK);
      // refresh on: entry index equal to block number asks for nothing
      add_row(1'b1, 48'd61, 6'd1, 16'hFFFF, 20'hFFFFF, 4'h0,
              1'b1, 1'b1, 6'd1, 1'b0, 32'd3, STATUS_OK);
      add_row(1'b1, 48'h0, 6'd0, 16'h0, 20'h0, 4'h0,
              1'b1, 1'b1, 6'd0, 1'b0, 32'd6, STATUS_OK);
      add_row(1'b1, 48'hFFFF_FFFF_FFC1, 6'd63, 16'h0, 20'h0, 4'h0,
              1'b1, 1'b1, 6'd0, 1'b1, 32'd7, STATUS_OK);
      add_row(1'b1, 48'd60, 6'd2, 16'h0, 20'h0, 4'h0,
              1'b1, 1'b1, 6'd1, 1'b1, 32'd4, STATUS_MISMATCH);
      add_row(1'b1, 48'hAAAA_AAAA_AAAA, 6'd2, 16'h5555, 20'hAAAAA, 4'h5,
              1'b0, 1'b0, 6'd0, 1'b0, 32'd0, STATUS_OK);
      add_row(1'b1, 48'h5555_5555_5555, 6'd42, 16'hAAAA, 20'h55555, 4'hA,
              1'b0, 1'b0, 6'd0, 1'b0, 32'd0, STATUS_OK);
      add_row(1'b1, 48'h8000_0000_0000, 6'd3, 16'h8000, 20'h80000, 4'h8,
              1'b0, 1'b0, 6'd0, 1'b0, 32'd0, STATUS_OK);
      add_row(1'b1, 48'hAAAA_AAAA_AAAC, 6'd0, 16'h5555, 20'hAAAAA, 4'h0,
              1'b1, 1'b1, 6'd2, 1'b1, 32'd2, STATUS_OK);
      add_row(1'b0, 48'hAAAA_AAAA_AAAC, 6'd0, 16'h5555, 20'hAAAAA, 4'h0,
              1'b1, 1'b1, 6'd2, 1'b0, 32'd3, STATUS_OK);
      add_row(1'b0, 48'h1, 6'd0, 16'h1, 20'h1, 4'h0,
              1'b1, 1'b0, 6'd5, 1'b1, 32'd1, STATUS_OK);
      add_row(1'b0, 48'h0000_1234_5678, 6'd63, 16'h7FFF, 20'h7FFFF, 4'h7,
              1'b1, 1'b0, 6'd6, 1'b1, 32'd1, STATUS_NEG_IDX);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_refresh(1'b0);
      foreach (directed_rows[k]) begin
         row = directed_rows[k];
         if (row.refresh != mdl_refresh_en) write_refresh(row.refresh);
         issue_request(row.req, row.typed, row.want);
         maybe_idle(1'b1);
      end

      // fill the table, then keep hammering it full under both refresh settings
      random_phase(1'b1, 220, 0);
      random_phase(1'b0, 200, 0);
      random_phase(1'b1, 230, 130);

      wait_drained();
      repeat (ENTRIES + 10) @(posedge clock);
      $display("Covered %0d lookups: %0d hits (%0d refreshed), %0d appends, %0d entries filled",
               n_hits + n_appends + n_full, n_hits, n_refresh, n_appends, mdl_fill);
      $display("Flagged %0d size mismatches, %0d full-table misses, %0d negative tally indexes",
               n_mismatch, n_full, n_neg);
      if (fail_count == 0 && pending_lookups.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d failures, %0d results outstanding", fail_count, pending_lookups.size());
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Timed out with %0d results outstanding", pending_lookups.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
